// File: src/pkc_pkg.sv
// shared constants and types of the periodic k-mer count table
`default_nettype none

package pkc_pkg;

    // default sizes of the table
    localparam int DEF_MAX_ORDER  = 5;
    localparam int DEF_MAX_PERIOD = 3;
    localparam int DEF_COUNT_BITS = 32;

    // one nucleotide
    localparam int BASE_BITS = 2;

    // configuration port
    localparam int ORDER_BITS      = 3;
    localparam int PERIOD_BITS     = 2;
    localparam int PERIOD_CMP_BITS = 4;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 3;

    localparam logic [ORDER_BITS-1:0]  ORDER_RESET  = 3'd2;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_ORDER   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_PERIOD = 2'd1;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_PRIMING   = 2'd0,
        STATUS_UPDATED   = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

endpackage

`default_nettype wire

// File: src/pkc_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module pkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/periodic_kmer_count_table.sv
// top level of the periodic k-mer count table
//
// s_* channel: one nucleotide per beat with its first-of-sequence, strand
//   and increment/decrement flags; accepted when s_valid and s_ready are high
// m_* channel: one result beat per input beat, in order: status, frame used,
//   masked word index and the count after the update
// cfg_* channel: register writes (index 0 word order, 1 frame period),
//   always ready; write only while no beat is in flight, the block does not enforce this
// path: an accepted beat is registered in the ram stage, then its result in the
//   output register on m_*; the beat waits in the ram stage while m_* is stalled
// throughput: one beat per cycle while m_ready is high; the count table is a single
//   ram with one read and one write port, read on acceptance and written back when
//   the beat leaves the ram stage, with the last write forwarded when the next beat hits the same entry
// reset: word, frame and priming state clear, the registers return to order 2
//   and period 3, then a clearing pass writes zero to every table entry, one
//   entry per cycle (MAX_PERIOD * 4^(MAX_ORDER+1) entries, 12288 by default);
//   s_ready stays low for that time
// stall: a low m_ready keeps the result in the output register; one more
//   beat can be taken into the ram stage behind it, then s_ready drops
`default_nettype none

module periodic_kmer_count_table
    import pkc_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration writes
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]                cfg_data,
    // input bases
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic [BASE_BITS-1:0]                    s_base,
    input  wire logic                                    s_first_of_sequence,
    input  wire logic                                    s_reverse_strand,
    input  wire logic                                    s_mode,
    // results
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [1:0]                                   m_status,
    output logic [((MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1)-1:0] m_frame_used,
    output logic [BASE_BITS*(MAX_ORDER+1)-1:0]           m_word_index,
    output logic [COUNT_BITS-1:0]                        m_new_count
);

    localparam int WORD_BITS   = BASE_BITS * (MAX_ORDER + 1);
    localparam int FRAME_BITS  = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int TABLE_DEPTH = MAX_PERIOD * (1 << WORD_BITS);
    localparam int RAM_AW      = $clog2(TABLE_DEPTH);

    localparam logic [RAM_AW-1:0]          CLEAR_LAST = RAM_AW'(TABLE_DEPTH - 1);
    localparam logic [COUNT_BITS-1:0]      COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [ORDER_BITS-1:0]      ORDER_CAP  = ORDER_BITS'(MAX_ORDER);
    localparam logic [PERIOD_CMP_BITS-1:0] PERIOD_CAP = PERIOD_CMP_BITS'(MAX_PERIOD);

    // configuration registers
    logic [ORDER_BITS-1:0]  order_reg;
    logic [PERIOD_BITS-1:0] period_reg;

    // sequence state
    logic [WORD_BITS-1:0]   word_reg, word_next;
    logic [FRAME_BITS-1:0]  frame_reg, frame_next;
    logic [ORDER_BITS-1:0]  primed_reg, primed_next;

    // clearing pass
    logic                   clear_busy_reg;
    logic [RAM_AW-1:0]      clear_addr_reg;

    // ram stage
    logic                   s1_valid_reg;
    logic                   s1_priming_reg;
    logic                   s1_dec_reg;
    logic [FRAME_BITS-1:0]  s1_frame_reg;
    logic [WORD_BITS-1:0]   s1_widx_reg;
    logic [RAM_AW-1:0]      s1_addr_reg;

    // last ram write, forwarded to a read that raced it
    logic                   fwd_valid_reg;
    logic [RAM_AW-1:0]      fwd_addr_reg;
    logic [COUNT_BITS-1:0]  fwd_data_reg;

    // output register
    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [FRAME_BITS-1:0]  m_frame_reg;
    logic [WORD_BITS-1:0]   m_widx_reg;
    logic [COUNT_BITS-1:0]  m_count_reg;

    // front-end signals
    logic                       s_accept;
    logic [ORDER_BITS-1:0]      eff_order;
    logic [PERIOD_CMP_BITS-1:0] eff_period;
    logic [BASE_BITS-1:0]       base_eff;
    logic [WORD_BITS-1:0]       word_base;
    logic [WORD_BITS-1:0]       widx;
    logic [FRAME_BITS-1:0]      frame_base;
    logic [PERIOD_CMP_BITS-1:0] frame_inc;
    logic [ORDER_BITS-1:0]      primed_base;
    logic                       priming;
    logic [RAM_AW-1:0]          s0_addr;

    // ram stage signals
    logic                       out_room;
    logic                       s1_adv;
    logic [COUNT_BITS-1:0]      rd_data;
    logic [COUNT_BITS-1:0]      cnt_old;
    logic [COUNT_BITS-1:0]      cnt_new;
    status_t                    s1_status;
    logic                       upd_we;
    logic                       ram_we;
    logic [RAM_AW-1:0]          ram_waddr;
    logic [COUNT_BITS-1:0]      ram_wdata;

    // handshakes
    assign cfg_ready = 1'b1;
    assign out_room  = !m_valid_reg || m_ready;
    assign s1_adv    = s1_valid_reg && out_room;
    assign s_ready   = !clear_busy_reg && (!s1_valid_reg || out_room);
    assign s_accept  = s_valid && s_ready;

    // effective order and period: saturate to the table size, period zero acts as one
    always_comb begin
        eff_order = (order_reg > ORDER_CAP) ? ORDER_CAP : order_reg;
        if (period_reg == '0) begin
            eff_period = PERIOD_CMP_BITS'(1);
        end else if (PERIOD_CMP_BITS'(period_reg) > PERIOD_CAP) begin
            eff_period = PERIOD_CAP;
        end else begin
            eff_period = PERIOD_CMP_BITS'(period_reg);
        end
    end

    // front end: word shift, masking, frame and priming, all from the beat on s_*
    always_comb begin
        // reverse strand complement: 3 minus base is the bitwise inverse
        base_eff    = s_reverse_strand ? ~s_base : s_base;
        word_base   = s_first_of_sequence ? '0 : word_reg;
        frame_base  = s_first_of_sequence ? '0 : frame_reg;
        primed_base = s_first_of_sequence ? '0 : primed_reg;

        word_next = WORD_BITS'({word_base, base_eff});

        // keep only the newest order+1 bases
        for (int i = 0; i <= MAX_ORDER; i++) begin
            if (i <= int'(eff_order)) begin
                widx[i*BASE_BITS +: BASE_BITS] = word_next[i*BASE_BITS +: BASE_BITS];
            end else begin
                widx[i*BASE_BITS +: BASE_BITS] = '0;
            end
        end

        // frame advances on every base; a frame left over from a larger period wraps to 0
        frame_inc  = PERIOD_CMP_BITS'(frame_base) + PERIOD_CMP_BITS'(1);
        frame_next = (frame_inc >= eff_period) ? '0 : FRAME_BITS'(frame_inc);

        priming     = primed_base < eff_order;
        primed_next = priming ? primed_base + ORDER_BITS'(1) : primed_base;

        // frame sits above the word bits; the frame is always below MAX_PERIOD
        s0_addr = RAM_AW'({frame_base, widx});
    end

    // configuration registers and sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg  <= ORDER_RESET;
            period_reg <= PERIOD_RESET;
            word_reg   <= '0;
            frame_reg  <= '0;
            primed_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WORD_ORDER) begin
                    order_reg <= cfg_data[ORDER_BITS-1:0];
                end else if (cfg_index == CFG_FRAME_PERIOD) begin
                    period_reg <= cfg_data[PERIOD_BITS-1:0];
                end
            end
            if (s_accept) begin
                word_reg   <= word_next;
                frame_reg  <= frame_next;
                primed_reg <= primed_next;
            end
        end
    end

    // clearing pass after reset, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clear_busy_reg) begin
            if (clear_addr_reg == CLEAR_LAST) begin
                clear_busy_reg <= 1'b0;
            end else begin
                clear_addr_reg <= clear_addr_reg + RAM_AW'(1);
            end
        end
    end

    // ram stage: beat whose table entry is on the ram read port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_priming_reg <= priming;
            s1_dec_reg     <= s_mode;
            s1_frame_reg   <= frame_base;
            s1_widx_reg    <= widx;
            s1_addr_reg    <= s0_addr;
        end
    end

    pkc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (s0_addr),
        .rdata (rd_data)
    );

    // read-modify: take the forwarded value when the previous write hit this entry
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) begin
            cnt_old = fwd_data_reg;
        end else begin
            cnt_old = rd_data;
        end

        priority if (s1_priming_reg) begin
            s1_status = STATUS_PRIMING;
            cnt_new   = '0;
        end else if (s1_dec_reg && (cnt_old == '0)) begin
            s1_status = STATUS_UNDERFLOW;
            cnt_new   = '0;
        end else if (s1_dec_reg) begin
            s1_status = STATUS_UPDATED;
            cnt_new   = cnt_old - COUNT_BITS'(1);
        end else begin
            // increment saturates at the top count
            s1_status = STATUS_UPDATED;
            cnt_new   = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_BITS'(1);
        end

        upd_we    = s1_adv && (s1_status == STATUS_UPDATED);
        ram_we    = clear_busy_reg || upd_we;
        ram_waddr = clear_busy_reg ? clear_addr_reg : s1_addr_reg;
        ram_wdata = clear_busy_reg ? '0 : cnt_new;
    end

    // forwarding register follows every ram write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (ram_we) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            fwd_addr_reg <= ram_waddr;
            fwd_data_reg <= ram_wdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_status_reg <= s1_status;
            m_frame_reg  <= s1_frame_reg;
            m_widx_reg   <= s1_widx_reg;
            m_count_reg  <= cnt_new;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_frame_used = m_frame_reg;
    assign m_word_index = m_widx_reg;
    assign m_new_count  = m_count_reg;

endmodule

`default_nettype wire

// File: src/pkc_checker.sv
// port-level checks of the periodic k-mer count table and their binding
`default_nettype none

module pkc_checker
    import pkc_pkg::*;
#(
    parameter int MAX_ORDER  = DEF_MAX_ORDER,
    parameter int MAX_PERIOD = DEF_MAX_PERIOD,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    cfg_valid,
    input  wire logic                                    cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]                cfg_data,
    input  wire logic                                    s_valid,
    input  wire logic                                    s_ready,
    input  wire logic [BASE_BITS-1:0]                    s_base,
    input  wire logic                                    s_first_of_sequence,
    input  wire logic                                    s_reverse_strand,
    input  wire logic                                    s_mode,
    input  wire logic                                    m_valid,
    input  wire logic                                    m_ready,
    input  wire logic [1:0]                              m_status,
    input  wire logic [((MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1)-1:0] m_frame_used,
    input  wire logic [BASE_BITS*(MAX_ORDER+1)-1:0]      m_word_index,
    input  wire logic [COUNT_BITS-1:0]                   m_new_count
);

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_new_count)
            && $stable(m_word_index) && $stable(m_frame_used))
        else $error("result beat changed while stalled");

    // priming and underflow beats report a zero count
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_PRIMING || m_status == STATUS_UNDERFLOW)
            |-> m_new_count == '0)
        else $error("non-zero count on a beat without update");

    // the frame used always addresses an existing frame table
    a_frame_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> int'(m_frame_used) < MAX_PERIOD)
        else $error("frame used beyond the table");

    // the clearing pass blocks input right after reset, and no result is pending
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_ready && !m_valid)
        else $error("input taken or result shown before the table was cleared");

endmodule

bind periodic_kmer_count_table pkc_checker #(
    .MAX_ORDER  (MAX_ORDER),
    .MAX_PERIOD (MAX_PERIOD),
    .COUNT_BITS (COUNT_BITS)
) u_pkc_checker (.*);

`default_nettype wire
